/* design/rsf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsf_pkg: shared types and constants for the sensor failover block
// Register indexes, status codes, config and result bundles, saturating add.
// ----------------------------------------------------------------------------
package rsf_pkg;

	localparam int FIELD_W   = 24;
	localparam int LIMIT_W   = 4;
	localparam int SWCNT_W   = 5;
	localparam int STATUS_W  = 2;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 24;

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_X     = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_Y     = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_Z     = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_SWITCH_LIMIT = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_FAULT_LIMIT  = 3'd4;

	// reset values of the limits
	localparam logic [LIMIT_W-1:0] SWITCH_LIMIT_RST = 4'd3;
	localparam logic [LIMIT_W-1:0] FAULT_LIMIT_RST  = 4'd6;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FAIL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FAULT = 2'd2;

	// sensor select codes
	localparam logic SENSOR_MAIN   = 1'b0;
	localparam logic SENSOR_BACKUP = 1'b1;

	localparam logic [SWCNT_W-1:0] SWCNT_MAX = 5'd31;

	localparam logic signed [FIELD_W-1:0] FIELD_MAX = 24'sh7FFFFF;
	localparam logic signed [FIELD_W-1:0] FIELD_MIN = 24'sh800000;

	typedef struct packed {
		logic signed [FIELD_W-1:0] offset_x;
		logic signed [FIELD_W-1:0] offset_y;
		logic signed [FIELD_W-1:0] offset_z;
		logic [LIMIT_W-1:0]        switch_limit;
		logic [LIMIT_W-1:0]        fault_limit;
	} cfg_t;

	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic signed [FIELD_W-1:0] field_x;
		logic signed [FIELD_W-1:0] field_y;
		logic signed [FIELD_W-1:0] field_z;
		logic                      sensor;
		logic                      fault_event;
	} res_t;

	// 24-bit add clamped to the signed field range
	function automatic logic signed [FIELD_W-1:0] sat_add(
		input logic signed [FIELD_W-1:0] a,
		input logic signed [FIELD_W-1:0] b
	);
		logic [FIELD_W:0] s;
		s = {a[FIELD_W-1], a} + {b[FIELD_W-1], b};
		if (s[FIELD_W] != s[FIELD_W-1]) begin
			sat_add = s[FIELD_W] ? FIELD_MIN : FIELD_MAX;
		end else begin
			sat_add = s[FIELD_W-1:0];
		end
	endfunction

endpackage
`default_nettype wire

/* design/rsf_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsf_cfg: configuration registers
// Offsets and limits, written through a plain index/data write port.
// ----------------------------------------------------------------------------
module rsf_cfg
	import rsf_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	// register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_x     <= '0;
			cfg_q.offset_y     <= '0;
			cfg_q.offset_z     <= '0;
			cfg_q.switch_limit <= SWITCH_LIMIT_RST;
			cfg_q.fault_limit  <= FAULT_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_OFFSET_X:     cfg_q.offset_x     <= cfg_wdata[FIELD_W-1:0];
				REG_OFFSET_Y:     cfg_q.offset_y     <= cfg_wdata[FIELD_W-1:0];
				REG_OFFSET_Z:     cfg_q.offset_z     <= cfg_wdata[FIELD_W-1:0];
				REG_SWITCH_LIMIT: cfg_q.switch_limit <= cfg_wdata[LIMIT_W-1:0];
				REG_FAULT_LIMIT:  cfg_q.fault_limit  <= cfg_wdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

/* design/rsf_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsf_core: failover state and held field
// Applies one read attempt per step: counters, sensor switch, fault latch,
// offset add with saturation. The result reflects the state after the step.
// ----------------------------------------------------------------------------
module rsf_core
	import rsf_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire cfg_t                      cfg,
	input  wire logic                      step,
	input  wire logic                      read_ok,
	input  wire logic signed [FIELD_W-1:0] sample_x,
	input  wire logic signed [FIELD_W-1:0] sample_y,
	input  wire logic signed [FIELD_W-1:0] sample_z,
	output res_t                           res
);

	logic                      active_q;
	logic [LIMIT_W-1:0]        fail_q;
	logic [SWCNT_W-1:0]        switch_q;
	logic                      fault_q;
	logic signed [FIELD_W-1:0] held_q [3];

	logic                      active_d;
	logic [LIMIT_W-1:0]        fail_d;
	logic [SWCNT_W-1:0]        switch_d;
	logic                      fault_d;
	logic signed [FIELD_W-1:0] held_d [3];

	logic                      fault_now;
	logic [LIMIT_W:0]          fail_inc;
	logic signed [FIELD_W-1:0] off_x, off_y, off_z;

	// fault check comes before anything else
	assign fault_now = fault_q || (switch_q > {1'b0, cfg.fault_limit});
	assign fail_inc  = {1'b0, fail_q} + 1'b1;

	// offsets only apply to the backup sensor
	assign off_x = (active_q == SENSOR_BACKUP) ? cfg.offset_x : '0;
	assign off_y = (active_q == SENSOR_BACKUP) ? cfg.offset_y : '0;
	assign off_z = (active_q == SENSOR_BACKUP) ? cfg.offset_z : '0;

	// next state for one read attempt
	always_comb begin
		active_d  = active_q;
		fail_d    = fail_q;
		switch_d  = switch_q;
		fault_d   = fault_q;
		held_d[0] = held_q[0];
		held_d[1] = held_q[1];
		held_d[2] = held_q[2];
		res.status = ST_FAIL;
		if (fault_now) begin
			fault_d    = 1'b1;
			res.status = ST_FAULT;
		end else if (read_ok) begin
			held_d[0]  = sat_add(sample_x, off_x);
			held_d[1]  = sat_add(sample_y, off_y);
			held_d[2]  = sat_add(sample_z, off_z);
			fail_d     = '0;
			switch_d   = '0;
			res.status = ST_OK;
		end else if (fail_inc > {1'b0, cfg.switch_limit}) begin
			active_d = ~active_q;
			fail_d   = '0;
			if (switch_q != SWCNT_MAX) begin
				switch_d = switch_q + 1'b1;
			end
		end else begin
			fail_d = fail_inc[LIMIT_W-1:0];
		end
		res.field_x     = held_d[0];
		res.field_y     = held_d[1];
		res.field_z     = held_d[2];
		res.sensor      = active_d;
		res.fault_event = fault_now && !fault_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= SENSOR_MAIN;
			fail_q   <= '0;
			switch_q <= '0;
			fault_q  <= 1'b0;
		end else if (step) begin
			active_q <= active_d;
			fail_q   <= fail_d;
			switch_q <= switch_d;
			fault_q  <= fault_d;
		end
	end

	// held field resets to zero since it is visible before the first good read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q[0] <= '0;
			held_q[1] <= '0;
			held_q[2] <= '0;
		end else if (step) begin
			held_q[0] <= held_d[0];
			held_q[1] <= held_d[1];
			held_q[2] <= held_d[2];
		end
	end

	// fault latch never clears outside reset
	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fault_q |=> fault_q)
		else $error("fault latch cleared");

	// a latched fault freezes the sensor and held field
	a_fault_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		step && fault_q |=> $stable(active_q) && $stable(held_q[0])
			&& $stable(held_q[1]) && $stable(held_q[2]))
		else $error("state moved after fault");

	// a good read outside fault clears both counters
	a_good_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && read_ok && !fault_now |=> fail_q == '0 && switch_q == '0)
		else $error("counters not cleared on good read");

	// counters only move on a step
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(switch_q) && $stable(fail_q) && $stable(active_q))
		else $error("state changed without a request");

endmodule
`default_nettype wire

/* design/redundant_sensor_failover.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// redundant_sensor_failover: main/backup magnetometer failover
// Holds the last good offset-corrected sample and switches sensors on
// repeated read failures, latching a fault after too many switches.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one read attempt per request: tuser = read_ok, tdata =
//   sample x/y/z. m_axis returns one result per request: tuser = status and
//   fault event, tdata = held field x/y/z and the sensor to read next.
//   cfg_we/cfg_addr/cfg_wdata write offsets (0..2) and the switch and fault
//   limits (3, 4); write only while no request is in flight.
// Path: a request accepted on s_axis passes through the input register and
//   then the result register before it shows on m_axis.
// Throughput: one request per cycle while m_axis takes results; the input register,
//   one pass through the counter and saturating adder logic, and the output register.
// Reset: counters, fault latch, held field and sensor select clear; limits
//   return to 3 and 6, offsets to zero. No result is pending after reset.
// Stall: while m_axis_tready is low the result holds; one more request is
//   kept in the input register, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module redundant_sensor_failover
	import rsf_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration write port
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	// read attempts in
	input  wire logic                  s_axis_tvalid,
	output      logic                  s_axis_tready,
	input  wire logic [71:0]           s_axis_tdata,  // sample_x, sample_y, sample_z
	input  wire logic                  s_axis_tuser,  // read_ok
	// results out
	output      logic                  m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output      logic [79:0]           m_axis_tdata,  // field_x, field_y, field_z,
	                                                  // selected_sensor, zero pad
	output      logic [2:0]            m_axis_tuser   // result_status, fault_event
);

	cfg_t cfg;
	res_t res;
	res_t res_q;

	logic                      valid_s1;
	logic                      ok_s1;
	logic signed [FIELD_W-1:0] x_s1, y_s1, z_s1;
	logic                      out_valid_q;
	logic                      adv;
	logic                      step;
	logic                      in_acc;

	// handshake: output register frees when empty or taken
	assign adv           = !out_valid_q || m_axis_tready;
	assign step          = valid_s1 && adv;
	assign s_axis_tready = !valid_s1 || adv;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	rsf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ok_s1 <= s_axis_tuser;
			x_s1  <= s_axis_tdata[23:0];
			y_s1  <= s_axis_tdata[47:24];
			z_s1  <= s_axis_tdata[71:48];
		end
	end

	rsf_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.step     (step),
		.read_ok  (ok_s1),
		.sample_x (x_s1),
		.sample_y (y_s1),
		.sample_z (z_s1),
		.res      (res)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, res_q.sensor, res_q.field_z, res_q.field_y, res_q.field_x};
	assign m_axis_tuser  = {res_q.fault_event, res_q.status};

endmodule
`default_nettype wire
